// ----- rtl/wws_pkg.sv -----
// ----------------------------------------------------------------------------
// Wavetable waveshaper package
// Shared constants, defaults and command codes for the waveshaper blocks.
// ----------------------------------------------------------------------------
package wws_pkg;

  // Default table geometry
  localparam int unsigned TABLE_LENGTH_DEF = 2048;
  localparam int unsigned TABLE_COUNT_DEF  = 256;

  // Command queue between front and back
  localparam int unsigned CMD_QUEUE_DEPTH  = 2;

  // Fixed field widths
  localparam int unsigned SAMPLE_W  = 24;  // Q1.23 samples and table entries
  localparam int unsigned FRAC_W    = 16;  // interpolation fractions
  localparam int unsigned ADDR_IN_W = 19;  // entry_address port
  localparam int unsigned CURVE_W   = 24;  // curve position, 8.16

  // Command kinds carried through the queue
  typedef enum logic {
    CMD_SHAPE = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_kind_e;

endpackage

// ----- rtl/wws_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module wws_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/wws_front.sv -----
// ----------------------------------------------------------------------------
// Waveshaper front end
// Accepts items, maps samples to a table index and fraction, drops writes
// beyond the table, and queues commands for the back end.
// ----------------------------------------------------------------------------
module wws_front import wws_pkg::*; #(
  parameter int unsigned TableLength = TABLE_LENGTH_DEF,
  parameter int unsigned TableCount  = TABLE_COUNT_DEF,
  parameter int unsigned QueueDepth  = CMD_QUEUE_DEPTH,
  localparam int unsigned Depth = TableLength * TableCount,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned IdxW  = $clog2(TableLength),
  localparam int unsigned CmdW  = 1 + AddrW + SAMPLE_W + IdxW + FRAC_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item side
  input  logic                       push,
  output logic                       full,
  input  logic                       action_i,
  input  logic signed [SAMPLE_W-1:0] audio_in_i,
  input  logic [ADDR_IN_W-1:0]       entry_address_i,
  input  logic signed [SAMPLE_W-1:0] entry_value_i,
  // command side
  output logic                       cmd_valid_o,
  output logic [CmdW-1:0]            cmd_o,
  input  logic                       cmd_pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned PosW = SAMPLE_W + IdxW;

  logic [SAMPLE_W-1:0] unsigned_x;
  logic [PosW-1:0]     pos;
  logic [IdxW-1:0]     idx;
  logic [FRAC_W-1:0]   frac;
  logic [31:0]         addr_ext;
  logic                wr_ok;
  logic                enq;
  logic [CmdW-1:0]     entry;

  logic [CmdW-1:0] q_mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // Sample to table position: (x + 1/2 full scale) * (length - 1), Q.24
  always_comb begin
    unsigned_x = audio_in_i ^ {1'b1, {(SAMPLE_W-1){1'b0}}};
    pos        = PosW'(unsigned_x) * PosW'(TableLength - 1);
    idx        = pos[PosW-1:SAMPLE_W];
    frac       = pos[SAMPLE_W-1:SAMPLE_W-FRAC_W];
  end

  // Classify: writes beyond the table are taken and dropped
  always_comb begin
    addr_ext = 32'(entry_address_i);
    wr_ok    = addr_ext < 32'(Depth);
    enq      = push && !full && (!action_i || wr_ok);
    if (action_i) begin
      entry = {CMD_WRITE, addr_ext[AddrW-1:0], entry_value_i,
               {IdxW{1'b0}}, {FRAC_W{1'b0}}};
    end else begin
      entry = {CMD_SHAPE, {AddrW{1'b0}}, {SAMPLE_W{1'b0}}, idx, frac};
    end
  end

  // Queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (enq && !cmd_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!enq && cmd_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem_q[wr_ptr_q] <= entry;
    end
  end

  assign full        = (count_q == CntW'(QueueDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("command queue count out of range");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o)
    else $error("command popped from empty queue");
  a_enq_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 && enq) |=> cmd_valid_o)
    else $error("queued command not visible to back end");
`endif

endmodule

// ----- rtl/wws_back.sv -----
// ----------------------------------------------------------------------------
// Waveshaper back end
// Executes queued commands: table writes, and four table reads with a shared
// multiplier for the bilinear interpolation, then rounds into the result slot.
// ----------------------------------------------------------------------------
module wws_back import wws_pkg::*; #(
  parameter int unsigned TableLength = TABLE_LENGTH_DEF,
  parameter int unsigned TableCount  = TABLE_COUNT_DEF,
  localparam int unsigned Depth = TableLength * TableCount,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned IdxW  = $clog2(TableLength),
  localparam int unsigned CmdW  = 1 + AddrW + SAMPLE_W + IdxW + FRAC_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [CURVE_W-1:0]         curve_position_i,
  // command side
  input  logic                       cmd_valid_i,
  input  logic [CmdW-1:0]            cmd_i,
  output logic                       cmd_pop_o,
  // table memory
  output logic                       ram_we_o,
  output logic [AddrW-1:0]           ram_addr_o,
  output logic [SAMPLE_W-1:0]        ram_wdata_o,
  input  logic [SAMPLE_W-1:0]        ram_rdata_i,
  // result side
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] audio_out_o
);

  localparam int unsigned DiffW = SAMPLE_W + 1;     // entry difference
  localparam int unsigned MulBW = FRAC_W + 1;       // signed fraction operand
  localparam int unsigned ProdW = DiffW + MulBW;    // multiplier result
  localparam int unsigned VW    = ProdW;            // one-curve interpolation
  localparam int unsigned AccW  = 60;               // final accumulator
  localparam int unsigned LowW  = 21;               // split of curve difference
  localparam int unsigned ShW   = AccW - 32;        // accumulator after >> 32
  localparam logic [CURVE_W-1:0] CurveMax = CURVE_W'((TableCount - 1) << FRAC_W);

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_RC, S_RD, S_RE, S_RF, S_RG, S_CA, S_CB, S_CC, S_CD, S_OUT
  } state_e;

  state_e state_q, state_d;

  // Command fields
  cmd_kind_e           cmd_kind;
  logic [AddrW-1:0]    cmd_addr;
  logic [SAMPLE_W-1:0] cmd_data;
  logic [IdxW-1:0]     cmd_idx;
  logic [FRAC_W-1:0]   cmd_frac;

  // Curve selection
  logic [CURVE_W-1:0]  cp_clamped;
  logic [7:0]          curve_lo, curve_hi;
  logic [FRAC_W-1:0]   curve_g;
  logic [31:0]         base_lo_full, base_hi_full;

  // Datapath registers
  logic [AddrW-1:0]         base_lo_q, base_hi_q;
  logic [FRAC_W-1:0]        frac_q, g_q;
  logic signed [SAMPLE_W-1:0] a_q;
  logic signed [DiffW-1:0]  d_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [VW-1:0]     v_q, w_q, dd_q;
  logic signed [AccW-1:0]   acc_q;

  logic signed [SAMPLE_W-1:0] rdata_s;
  logic signed [DiffW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  mul_p;

  // Output slot
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_data_q;
  logic                       out_pop;
  logic                       out_push;
  logic signed [AccW-1:0]     rounded;
  logic signed [ShW-1:0]      shifted;
  logic signed [SAMPLE_W-1:0] sat_val;

  // Unpack command
  always_comb begin
    cmd_kind = cmd_kind_e'(cmd_i[CmdW-1]);
    cmd_addr = cmd_i[CmdW-2 -: AddrW];
    cmd_data = cmd_i[IdxW+FRAC_W +: SAMPLE_W];
    cmd_idx  = cmd_i[FRAC_W +: IdxW];
    cmd_frac = cmd_i[FRAC_W-1:0];
  end

  // Curve pair and base addresses
  always_comb begin
    cp_clamped   = (curve_position_i > CurveMax) ? CurveMax : curve_position_i;
    curve_lo     = cp_clamped[CURVE_W-1:FRAC_W];
    curve_g      = cp_clamped[FRAC_W-1:0];
    curve_hi     = (curve_g != '0) ? curve_lo + 8'd1 : curve_lo;
    base_lo_full = 32'(curve_lo) * 32'(TableLength) + 32'(cmd_idx);
    base_hi_full = 32'(curve_hi) * 32'(TableLength) + 32'(cmd_idx);
  end

  // Sequencer control
  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    ram_we_o   = 1'b0;
    ram_addr_o = base_lo_q;
    out_push   = 1'b0;
    case (state_q)
      S_IDLE: begin
        ram_addr_o = cmd_addr;
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_kind == CMD_WRITE) begin
            ram_we_o = 1'b1;
          end else begin
            state_d = S_RA;
          end
        end
      end
      S_RA: state_d = S_RB;
      S_RB: begin
        ram_addr_o = base_lo_q + 1'b1;
        state_d    = S_RC;
      end
      S_RC: begin
        ram_addr_o = base_hi_q;
        state_d    = S_RD;
      end
      S_RD: begin
        ram_addr_o = base_hi_q + 1'b1;
        state_d    = S_RE;
      end
      S_RE: state_d = S_RF;
      S_RF: state_d = S_RG;
      S_RG: state_d = S_CA;
      S_CA: state_d = S_CB;
      S_CB: state_d = S_CC;
      S_CC: state_d = S_CD;
      S_CD: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || pop) begin
          out_push = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ram_wdata_o = cmd_data;
  assign rdata_s     = signed'(ram_rdata_i);

  // Shared multiplier operand selection
  always_comb begin
    mul_a = d_q;
    mul_b = signed'({1'b0, frac_q});
    case (state_q)
      S_CB: begin
        mul_a = signed'(DiffW'(dd_q[LowW-1:0]));
        mul_b = signed'({1'b0, g_q});
      end
      S_CC: begin
        mul_a = DiffW'(signed'(dd_q[VW-1:LowW]));
        mul_b = signed'({1'b0, g_q});
      end
      default: begin
        mul_a = d_q;
        mul_b = signed'({1'b0, frac_q});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Interpolation datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        base_lo_q <= base_lo_full[AddrW-1:0];
        base_hi_q <= base_hi_full[AddrW-1:0];
        frac_q    <= cmd_frac;
        g_q       <= curve_g;
      end
      S_RB: a_q <= rdata_s;
      S_RC: begin
        d_q <= DiffW'(rdata_s) - DiffW'(a_q);
        v_q <= VW'(a_q) <<< FRAC_W;
      end
      S_RD: begin
        prod_q <= mul_p;
        a_q    <= rdata_s;
      end
      S_RE: begin
        v_q <= v_q + prod_q;
        d_q <= DiffW'(rdata_s) - DiffW'(a_q);
        w_q <= VW'(a_q) <<< FRAC_W;
      end
      S_RF: prod_q <= mul_p;
      S_RG: w_q <= w_q + prod_q;
      S_CA: begin
        dd_q  <= w_q - v_q;
        acc_q <= AccW'(v_q) <<< FRAC_W;
      end
      S_CB: prod_q <= mul_p;
      S_CC: begin
        acc_q  <= acc_q + AccW'(prod_q);
        prod_q <= mul_p;
      end
      S_CD: acc_q <= acc_q + (AccW'(prod_q) <<< LowW);
      default: ;
    endcase
  end

  // Round half up, drop 32 fraction bits, saturate to Q1.23
  always_comb begin
    rounded = acc_q + (AccW'(1) <<< 31);
    shifted = signed'(rounded[AccW-1:32]);
    if (shifted > ShW'(8388607)) begin
      sat_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (shifted < -ShW'(8388608)) begin
      sat_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_val = shifted[SAMPLE_W-1:0];
    end
  end

  assign out_pop = pop && out_valid_q;

  // State and result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_push) begin
        out_valid_q <= 1'b1;
        out_data_q  <= sat_val;
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty       = !out_valid_q;
  assign audio_out_o = out_data_q;

`ifndef ASSERT_OFF
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> (!out_valid_q || pop))
    else $error("result overwritten before it was taken");
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == S_IDLE && cmd_valid_i))
    else $error("table write outside idle");
  a_out_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not delivered to the slot");
`endif

endmodule

// ----- rtl/wavetable_waveshaper_bilinear.sv -----
// ----------------------------------------------------------------------------
// Wavetable waveshaper, bilinear interpolation
// Top level: front end, command queue, back end and curve table memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full): one beat is a write (action_i = 1, stores
//   entry_value_i at entry_address_i; addresses beyond the table are dropped)
//   or a shape request (action_i = 0, audio_in_i in Q1.23). Writes give no
//   result. Result channel (empty/pop): one audio_out_o beat per shape beat,
//   in order. curve_position_i (8.16) is written with cfg_we_i; the user
//   must do so only while idle, as the block does not enforce it. A shape
//   beat makes four reads through the single port of the table memory and
//   four passes through one shared multiplier, then is rounded into the
//   result slot; a write is done in the idle state. The back end starts the
//   next command only once a shape result has been handed to the result slot.
//   A two-entry command queue lets the input side keep accepting while a
//   result waits; a stalled receiver halts the back end at its last step.
//   Reset empties the queue and result slot and clears curve_position;
//   table contents are undefined until software loads them.
// ----------------------------------------------------------------------------
module wavetable_waveshaper_bilinear import wws_pkg::*; #(
  parameter int unsigned TableLength = TABLE_LENGTH_DEF,
  parameter int unsigned TableCount  = TABLE_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [CURVE_W-1:0]         curve_position_i,
  // items
  input  logic                       push,
  output logic                       full,
  input  logic                       action_i,
  input  logic signed [SAMPLE_W-1:0] audio_in_i,
  input  logic [ADDR_IN_W-1:0]       entry_address_i,
  input  logic signed [SAMPLE_W-1:0] entry_value_i,
  // results
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] audio_out_o
);

  localparam int unsigned Depth = TableLength * TableCount;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned IdxW  = $clog2(TableLength);
  localparam int unsigned CmdW  = 1 + AddrW + SAMPLE_W + IdxW + FRAC_W;

  logic [CURVE_W-1:0]  curve_position_q;
  logic                cmd_valid;
  logic [CmdW-1:0]     cmd;
  logic                cmd_pop;
  logic                ram_we;
  logic [AddrW-1:0]    ram_addr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Curve position register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_position_q <= '0;
    end else if (cfg_we_i) begin
      curve_position_q <= curve_position_i;
    end
  end

  wws_front #(
    .TableLength (TableLength),
    .TableCount  (TableCount),
    .QueueDepth  (CMD_QUEUE_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .action_i        (action_i),
    .audio_in_i      (audio_in_i),
    .entry_address_i (entry_address_i),
    .entry_value_i   (entry_value_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  wws_back #(
    .TableLength (TableLength),
    .TableCount  (TableCount)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .curve_position_i (curve_position_q),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .ram_we_o         (ram_we),
    .ram_addr_o       (ram_addr),
    .ram_wdata_o      (ram_wdata),
    .ram_rdata_i      (ram_rdata),
    .empty            (empty),
    .pop              (pop),
    .audio_out_o      (audio_out_o)
  );

  wws_ram #(
    .Width (SAMPLE_W),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- tb/sv/tb_wavetable_waveshaper_bilinear.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the bilinear wavetable waveshaper
// Loads curve table entries on demand and shapes samples under several morph
// positions. Every output beat is compared in order against a fixed-point
// predictor that keeps its own copy of the table and the curve position.
// ----------------------------------------------------------------------------
module tb_wavetable_waveshaper_bilinear;
  import wws_pkg::*;

  localparam int unsigned TBL_DEPTH   = TABLE_COUNT_DEF * TABLE_LENGTH_DEF;
  localparam int unsigned CURVE_MAX   = (TABLE_COUNT_DEF - 1) << FRAC_W;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned IDLE_WAIT   = 24;  // back-end latency plus queued writes
  localparam int unsigned PHASE_BEATS = 110;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned NUM_ROWS    = 22;

  // Directed stimulus row; typed_out is used only where has_typed is set
  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [SAMPLE_W-1:0] audio;
    logic [ADDR_IN_W-1:0]      addr;
    logic signed [SAMPLE_W-1:0] value;
    logic                      has_typed;
    logic signed [SAMPLE_W-1:0] typed_out;
  } dir_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CURVE_W-1:0]         curve_position_i;
  logic                       push;
  logic                       full;
  logic                       action_i;
  logic signed [SAMPLE_W-1:0] audio_in_i;
  logic [ADDR_IN_W-1:0]       entry_address_i;
  logic signed [SAMPLE_W-1:0] entry_value_i;
  logic                       empty;
  logic                       pop;
  logic signed [SAMPLE_W-1:0] audio_out_o;

  // Predictor state: written table entries and the morph position
  logic signed [SAMPLE_W-1:0] curve_mem [int unsigned];
  logic [CURVE_W-1:0]         curve_pos_q;
  logic signed [SAMPLE_W-1:0] pending_outputs [$];
  logic signed [SAMPLE_W-1:0] last_audio;

  bit          idle_on;
  int unsigned beats_sent;
  int unsigned n_shapes;
  int unsigned n_writes;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_settings;
  int unsigned cycle_count;

  // Directed rows, all at curve position 0 (reset value)
  dir_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{CMD_WRITE, 24'sd0,       19'd0,      24'sh7FFFFF,  1'b0, 24'sd0},
    '{CMD_WRITE, 24'sd0,       19'd1,      24'sh800000,  1'b0, 24'sd0},
    // lowest sample lands exactly on entry 0
    '{CMD_SHAPE, 24'sh800000,  19'd0,      24'sd0,       1'b1, 24'sh7FFFFF},
    '{CMD_WRITE, 24'sd0,       19'd0,      24'sh800000,  1'b0, 24'sd0},
    '{CMD_SHAPE, 24'sh800000,  19'd0,      24'sd0,       1'b1, 24'sh800000},
    // zero input sits halfway between 1023 and 1024: ties round upward
    '{CMD_WRITE, 24'sd0,       19'd1023,   24'sd100,     1'b0, 24'sd0},
    '{CMD_WRITE, 24'sd0,       19'd1024,   24'sd201,     1'b0, 24'sd0},
    '{CMD_SHAPE, 24'sd0,       19'd0,      24'sd0,       1'b1, 24'sd151},
    '{CMD_WRITE, 24'sd0,       19'd1023,   -24'sd101,    1'b0, 24'sd0},
    '{CMD_WRITE, 24'sd0,       19'd1024,   -24'sd200,    1'b0, 24'sd0},
    '{CMD_SHAPE, 24'sd0,       19'd0,      24'sd0,       1'b1, -24'sd150},
    // top sample interpolates between the last two entries
    '{CMD_WRITE, 24'sd0,       19'd2046,   24'sh7FFFFF,  1'b0, 24'sd0},
    '{CMD_WRITE, 24'sd0,       19'd2047,   24'sh7FFFFF,  1'b0, 24'sd0},
    '{CMD_SHAPE, 24'sh7FFFFF,  19'd0,      24'sd0,       1'b1, 24'sh7FFFFF},
    '{CMD_WRITE, 24'sd0,       19'd2047,   24'sh800000,  1'b0, 24'sd0},
    '{CMD_SHAPE, 24'sh7FFFFF,  19'd0,      24'sd0,       1'b0, 24'sd0},
    // address extremes
    '{CMD_WRITE, 24'sd0,       19'h7FFFF,  24'sh555555,  1'b0, 24'sd0},
    '{CMD_WRITE, 24'sd0,       19'h2AAAA,  24'sh2AAAAA,  1'b0, 24'sd0},
    '{CMD_SHAPE, -24'sd1,      19'd0,      24'sd0,       1'b0, 24'sd0},
    '{CMD_SHAPE, 24'sd1,       19'd0,      24'sd0,       1'b0, 24'sd0},
    '{CMD_SHAPE, 24'sh400000,  19'd0,      24'sd0,       1'b0, 24'sd0},
    '{CMD_SHAPE, 24'shC00000,  19'd0,      24'sd0,       1'b0, 24'sd0}
  };

  wavetable_waveshaper_bilinear dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .curve_position_i (curve_position_i),
    .push             (push),
    .full             (full),
    .action_i         (action_i),
    .audio_in_i       (audio_in_i),
    .entry_address_i  (entry_address_i),
    .entry_value_i    (entry_value_i),
    .empty            (empty),
    .pop              (pop),
    .audio_out_o      (audio_out_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Table taps and fractions for one sample at the current morph position
  function automatic void shape_taps(input logic signed [SAMPLE_W-1:0] x,
                                     output int unsigned lo_base,
                                     output int unsigned hi_base,
                                     output longint f, output longint g);
    longint      pos;
    int unsigned cp;
    int unsigned clo;
    int unsigned idx;
    pos = (longint'(x) + 64'sd8388608) * longint'(TABLE_LENGTH_DEF - 1);
    idx = int'(pos >>> 24);
    f   = (pos >>> 8) & 64'shFFFF;
    cp  = 32'(curve_pos_q);
    if (cp > CURVE_MAX) cp = CURVE_MAX;  // clamp past the last curve
    clo = cp >> FRAC_W;
    g   = longint'(cp & 32'hFFFF);
    lo_base = clo * TABLE_LENGTH_DEF + idx;
    hi_base = ((g != 0) ? clo + 1 : clo) * TABLE_LENGTH_DEF + idx;
  endfunction

  // Expected shaped sample: lerp along each curve, then across curves
  function automatic logic signed [SAMPLE_W-1:0] shape_sample(
      input logic signed [SAMPLE_W-1:0] x);
    int unsigned lo_b;
    int unsigned hi_b;
    longint      f;
    longint      g;
    longint      vlo;
    longint      vhi;
    longint      s;
    longint      r;
    shape_taps(x, lo_b, hi_b, f, g);
    vlo = longint'(curve_mem[lo_b]) * (65536 - f) + longint'(curve_mem[lo_b + 1]) * f;
    vhi = longint'(curve_mem[hi_b]) * (65536 - f) + longint'(curve_mem[hi_b + 1]) * f;
    s   = vlo * (65536 - g) + vhi * g;
    r   = (s + (64'sd1 <<< 31)) >>> 32;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[SAMPLE_W-1:0];
  endfunction

  // One input beat; called at a falling edge, returns at a falling edge
  task automatic push_beat(input cmd_kind_e kind,
                           input logic signed [SAMPLE_W-1:0] audio,
                           input logic [ADDR_IN_W-1:0] addr,
                           input logic signed [SAMPLE_W-1:0] value,
                           input logic has_typed,
                           input logic signed [SAMPLE_W-1:0] typed_out);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap  = $urandom_range(1, 5);
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i        = kind;
    audio_in_i      = audio;
    entry_address_i = addr;
    entry_value_i   = value;
    push            = 1'b1;
    do @(posedge clk_i); while (full);
    // beat accepted: update the predictor
    if (kind == CMD_WRITE) begin
      if (addr < TBL_DEPTH) curve_mem[addr] = value;
      n_writes++;
    end else begin
      pending_outputs.push_back(has_typed ? typed_out : shape_sample(audio));
      last_audio = audio;
      n_shapes++;
    end
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Shape beat, preceded by writes for any tap not yet loaded
  task automatic send_shape(input logic signed [SAMPLE_W-1:0] x,
                            input logic has_typed,
                            input logic signed [SAMPLE_W-1:0] typed_out);
    int unsigned lo_b;
    int unsigned hi_b;
    longint      f;
    longint      g;
    int unsigned taps [4];
    shape_taps(x, lo_b, hi_b, f, g);
    taps = '{lo_b, lo_b + 1, hi_b, hi_b + 1};
    foreach (taps[i]) begin
      if (!curve_mem.exists(taps[i]))
        push_beat(CMD_WRITE, SAMPLE_W'($urandom), taps[i][ADDR_IN_W-1:0],
                  SAMPLE_W'($urandom), 1'b0, '0);
    end
    push_beat(CMD_SHAPE, x, ADDR_IN_W'($urandom), SAMPLE_W'($urandom), has_typed,
              typed_out);
  endtask

  // Morph position change, only once the block has gone idle
  task automatic set_curve_position(input logic [CURVE_W-1:0] pos_val);
    push = 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk_i);
    repeat (IDLE_WAIT) @(negedge clk_i);
    cfg_we_i         = 1'b1;
    curve_position_i = pos_val;
    curve_pos_q      = pos_val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    n_settings++;
  endtask

  // One random beat: mostly shapes, some overwrites of live or random entries
  task automatic random_item();
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] v;
    logic [ADDR_IN_W-1:0]       addr;
    int unsigned                lo_b;
    int unsigned                hi_b;
    longint                     f;
    longint                     g;
    int unsigned                pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      x = SAMPLE_W'($urandom);
      shape_taps(x, lo_b, hi_b, f, g);
      if ($urandom_range(0, 1)) addr = ADDR_IN_W'($urandom);
      else addr = ADDR_IN_W'(($urandom_range(0, 1) ? lo_b : hi_b) + $urandom_range(0, 1));
      v = SAMPLE_W'($urandom);
      if ($urandom_range(0, 6) == 0) v = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      push_beat(CMD_WRITE, SAMPLE_W'($urandom), addr, v, 1'b0, '0);
    end else begin
      if (pick < 78) x = SAMPLE_W'($urandom);
      else if (pick < 86) begin
        case ($urandom_range(0, 3))
          0:       x = 24'sh800000;
          1:       x = 24'sh7FFFFF;
          2:       x = 24'sd0;
          default: x = -24'sd1;
        endcase
      end else begin
        // near the previous one
        x = SAMPLE_W'(last_audio + $urandom_range(0, 1024) - 512);
      end
      send_shape(x, 1'b0, '0);
    end
  endtask

  // Receiver: pop with random stall bursts
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        pop = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        pop = 1'b0;
      end else begin
        pop = 1'b1;
      end
    end
  end

  // Output check against the oldest pending expectation
  always @(posedge clk_i) begin : check_out
    logic signed [SAMPLE_W-1:0] want;
    if (rst_ni && pop && !empty) begin
      if (pending_outputs.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected audio_out beat, expected none, actual %0d",
                 $time, audio_out_o);
      end else begin
        want = pending_outputs.pop_front();
        n_checked++;
        if (audio_out_o !== want) begin
          n_errors++;
          $display("%0t: audio_out mismatch, expected %0d, actual %0d",
                   $time, want, audio_out_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d outputs pending", $time, pending_outputs.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [CURVE_W-1:0] phase_pos [NUM_PHASES];
    int unsigned        phase_end;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    curve_position_i = '0;
    push             = 1'b0;
    action_i         = CMD_SHAPE;
    audio_in_i       = '0;
    entry_address_i  = '0;
    entry_value_i    = '0;
    curve_pos_q      = '0;
    last_audio       = '0;
    idle_on          = 1'b1;
    beats_sent       = 0;
    n_shapes         = 0;
    n_writes         = 0;
    n_checked        = 0;
    n_errors         = 0;
    n_settings       = 0;
    cycle_count      = 0;
    // last curve, past the last curve (clamped), near-edge fractions, random
    phase_pos = '{24'h00FFFF, 24'h008000, 24'hFF0000, 24'hFFFFFF,
                  24'hFEC000, 24'h000000, 24'h000000, 24'h010000};
    phase_pos[5] = CURVE_W'($urandom);
    phase_pos[6] = CURVE_W'($urandom);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == CMD_WRITE)
        push_beat(CMD_WRITE, SAMPLE_W'($urandom), directed_rows[i].addr,
                  directed_rows[i].value, 1'b0, '0);
      else
        send_shape(directed_rows[i].audio, directed_rows[i].has_typed,
                   directed_rows[i].typed_out);
    end

    // random phases, one morph position each; the last runs without idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_curve_position(phase_pos[p]);
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) random_item();
    end
    push = 1'b0;

    // drain, then allow for any stray beat
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT * 2) @(posedge clk_i);

    $display("Sent %0d shape beats and %0d table writes across %0d morph positions.",
             n_shapes, n_writes, n_settings + 1);
    $display("Checked %0d output beats, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
